>>> design/fbpa_pkg.sv
// Shared widths, codes and defaults of the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

    // Field widths of the request, response and configuration register.
    localparam int KIND_W   = 1;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Default pool capacity.
    localparam int DEF_MAX_BLOCKS = 256;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

endpackage

>>> design/fbpa_if.sv
// Request and response channel interfaces of the fixed block pool allocator.
`timescale 1ns / 1ps

interface fbpa_req_if
    import fbpa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] block_index;

    modport source (output valid, output kind, output block_index, input ready);
    modport sink   (input valid, input kind, input block_index, output ready);
endinterface

interface fbpa_rsp_if
    import fbpa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_index;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, output status, output granted_index,
                    output free_count, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input free_count, output ready);
endinterface

>>> design/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: a LIFO free list held in one memory.
//
//  Channel   Direction  Contents
//  i_req     in         kind (alloc/free), block_index
//  o_rsp     out        status, granted_index, free_count
//  i_cfg_*   in         block_count write (restarts the pool)
//
// Each request is taken in S_IDLE, where its memory entry is read (the head link
// for an allocate, the in-use mark for a free), and decided and written back in S_EXEC.
// As the memory's read port is registered, no new request is taken while one is in S_EXEC.
// The response register lets a new request be taken while a response waits;
// a request whose response cannot yet be loaded holds in S_EXEC.
// Reset is synchronous and needs no clearing pass: blocks at or above the
// fresh pointer read as unused, so stale memory contents are never observed.
`timescale 1ns / 1ps

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fbpa_req_if.sink           i_req,
    fbpa_rsp_if.source         o_rsp,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata
);

    // Memory address width and head width (the head also holds the empty mark).
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int HW = IW + 1;
    localparam int RESET_COUNT = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
    localparam logic [HW-1:0] HEAD_EMPTY = HW'(MAX_BLOCKS);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    // Control and datapath registers.
    t_state              r_state,       n_state;
    logic [KIND_W-1:0]   r_kind,        n_kind;
    logic [INDEX_W-1:0]  r_idx,         n_idx;
    logic [COUNT_W-1:0]  r_block_count, n_block_count;
    logic [HW-1:0]       r_head,        n_head;
    logic [COUNT_W-1:0]  r_fresh_next,  n_fresh_next;
    logic [COUNT_W-1:0]  r_free_blocks, n_free_blocks;
    logic                r_out_valid,   n_out_valid;
    logic [STATUS_W-1:0] r_status,      n_status;
    logic [INDEX_W-1:0]  r_granted,     n_granted;
    logic [COUNT_W-1:0]  r_free_count,  n_free_count;

    // Memory: each entry holds the in-use mark and the next link.
    logic [HW:0]   r_mem [MAX_BLOCKS];
    logic [HW:0]   r_rd_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [HW:0]   wr_data;

    logic               req_accept;
    logic               finish;
    logic [COUNT_W-1:0] idx_ext;
    logic [COUNT_W-1:0] req_idx_ext;
    logic [COUNT_W-1:0] cfg_count;
    logic               stack_hit;
    logic               fresh_hit;
    logic               idx_in_use;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_accept  = i_req.valid && (r_state == S_IDLE);
    assign finish      = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    assign idx_ext     = {1'b0, r_idx};
    assign req_idx_ext = {1'b0, i_req.block_index};

    // Saturate the written block count into the range one to the capacity.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_count = COUNT_W'(1);
        end else if ({23'd0, i_cfg_wdata} > 32'(MAX_BLOCKS)) begin
            cfg_count = COUNT_W'(MAX_BLOCKS);
        end else begin
            cfg_count = i_cfg_wdata;
        end
    end

    // Read port: the head entry for an allocate, the named block for a free.
    always_comb begin
        if (i_req.kind == KIND_FREE) begin
            rd_en   = req_accept && (req_idx_ext < r_block_count);
            rd_addr = IW'(i_req.block_index);
        end else begin
            rd_en   = req_accept && (r_head != HEAD_EMPTY);
            rd_addr = IW'(r_head);
        end
    end

    // Decisions taken once the entry has been read.
    assign stack_hit  = (r_free_blocks != '0) && (r_head < HEAD_EMPTY);
    assign fresh_hit  = (r_free_blocks != '0) && (r_fresh_next < r_block_count);
    assign idx_in_use = (idx_ext < r_fresh_next) && r_rd_data[HW];

    // Next-state logic for the sequencer, pool state and response register.
    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        n_idx         = r_idx;
        n_block_count = r_block_count;
        n_head        = r_head;
        n_fresh_next  = r_fresh_next;
        n_free_blocks = r_free_blocks;
        n_out_valid   = r_out_valid;
        n_status      = r_status;
        n_granted     = r_granted;
        n_free_count  = r_free_count;
        wr_en         = 1'b0;
        wr_addr       = IW'(r_idx);
        wr_data       = {1'b0, r_head};

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_accept) begin
                    n_kind  = i_req.kind;
                    n_idx   = i_req.block_index;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (finish) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = STATUS_OK;
                    n_granted   = '0;
                    if (r_kind == KIND_ALLOC) begin
                        if (stack_hit) begin
                            // Pop a returned block and keep its link as the new head.
                            wr_en         = 1'b1;
                            wr_addr       = IW'(r_head);
                            wr_data       = {1'b1, r_rd_data[HW-1:0]};
                            n_head        = r_rd_data[HW-1:0];
                            n_granted     = INDEX_W'(r_head);
                            n_free_blocks = r_free_blocks - COUNT_W'(1);
                        end else if (fresh_hit) begin
                            // Hand out the next block that has never been used.
                            wr_en         = 1'b1;
                            wr_addr       = IW'(r_fresh_next);
                            wr_data       = {1'b1, HEAD_EMPTY};
                            n_fresh_next  = r_fresh_next + COUNT_W'(1);
                            n_granted     = INDEX_W'(r_fresh_next);
                            n_free_blocks = r_free_blocks - COUNT_W'(1);
                        end else begin
                            n_status = STATUS_EMPTY;
                        end
                    end else begin
                        if ((idx_ext >= r_block_count) || !idx_in_use ||
                            (r_free_blocks >= r_block_count)) begin
                            n_status = STATUS_INVALID;
                        end else begin
                            // Push the block onto the head of the free list.
                            wr_en         = 1'b1;
                            wr_addr       = IW'(r_idx);
                            wr_data       = {1'b0, r_head};
                            n_head        = HW'(r_idx);
                            n_free_blocks = r_free_blocks + COUNT_W'(1);
                        end
                    end
                    n_free_count = n_free_blocks;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A block count write restarts the pool.
        if (i_cfg_we) begin
            n_block_count = cfg_count;
            n_head        = HEAD_EMPTY;
            n_fresh_next  = '0;
            n_free_blocks = cfg_count;
        end
    end

    // State, request payload and registered response.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_kind        <= KIND_ALLOC;
            r_idx         <= '0;
            r_block_count <= COUNT_W'(RESET_COUNT);
            r_head        <= HEAD_EMPTY;
            r_fresh_next  <= '0;
            r_free_blocks <= COUNT_W'(RESET_COUNT);
            r_out_valid   <= 1'b0;
            r_status      <= STATUS_OK;
            r_granted     <= '0;
            r_free_count  <= COUNT_W'(RESET_COUNT);
        end else begin
            r_state       <= n_state;
            r_kind        <= n_kind;
            r_idx         <= n_idx;
            r_block_count <= n_block_count;
            r_head        <= n_head;
            r_fresh_next  <= n_fresh_next;
            r_free_blocks <= n_free_blocks;
            r_out_valid   <= n_out_valid;
            r_status      <= n_status;
            r_granted     <= n_granted;
            r_free_count  <= n_free_count;
        end
    end

    // Free list memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.granted_index = r_granted;
    assign o_rsp.free_count    = r_free_count;

    // The free count never exceeds the pool size.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_blocks <= r_block_count)
        else $error("free block count exceeds block count");

    // The fresh pointer never passes the pool size.
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh_next <= r_block_count)
        else $error("fresh pointer beyond block count");

    // The head is either empty or a block inside the pool.
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == HEAD_EMPTY) || (32'(r_head) < 32'(r_block_count)))
        else $error("free list head out of range");

    // An accepted request always moves on to its write-back cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    // A failed request never reports a granted index.
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != STATUS_OK)) |-> (r_granted == '0))
        else $error("granted index set on a response without a grant");

endmodule

>>> verif/fbpa_pool_checker.sv
// Checker of the fixed block pool allocator: tracks the pool and compares every response.
`timescale 1ns / 1ps

module fbpa_pool_checker
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fbpa_req_if                i_req_mon,
    fbpa_rsp_if                i_rsp_mon,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_rsp_seen
);

    // One response as the pool should give it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted_index;
        logic [COUNT_W-1:0]  free_count;
    } t_pool_outcome;

    localparam int          REPORT_LIMIT      = 10;
    localparam int unsigned RESET_BLOCK_COUNT = 256;

    // Shadow copy of the pool.
    int unsigned   pool_size;
    int unsigned   list_head;
    int unsigned   fresh_ptr;
    int unsigned   free_now;
    int unsigned   next_link [MAX_BLOCKS];
    bit            used_mark [MAX_BLOCKS];
    t_pool_outcome outcome_q[$];
    int            fail_total;
    int            seen_total;

    // Restarts the pool with every block free; the size is clamped to 1..MAX_BLOCKS.
    function automatic void restart_pool(input int unsigned size);
        if (size == 0) begin
            pool_size = 1;
        end else if (size > MAX_BLOCKS) begin
            pool_size = MAX_BLOCKS;
        end else begin
            pool_size = size;
        end
        for (int b = 0; b < MAX_BLOCKS; b++) begin
            used_mark[b] = 1'b0;
        end
        list_head = MAX_BLOCKS;
        fresh_ptr = 0;
        free_now  = pool_size;
    endfunction

    // Applies one request to the shadow pool and returns the response it should give.
    function automatic t_pool_outcome apply_request(input logic [KIND_W-1:0]  kind,
                                                    input logic [INDEX_W-1:0] idx);
        t_pool_outcome res;
        int unsigned   blk;
        res.status        = STATUS_OK;
        res.granted_index = '0;
        blk               = 0;
        if (kind == KIND_ALLOC) begin
            // Returned blocks go out first, then blocks never handed out, in order.
            if (free_now != 0 && list_head < MAX_BLOCKS) begin
                blk       = list_head;
                list_head = next_link[blk];
            end else if (free_now != 0 && fresh_ptr < pool_size) begin
                blk       = fresh_ptr;
                fresh_ptr = fresh_ptr + 1;
            end else begin
                res.status = STATUS_EMPTY;
            end
            if (res.status == STATUS_OK) begin
                used_mark[blk]    = 1'b1;
                free_now          = free_now - 1;
                res.granted_index = INDEX_W'(blk);
            end
        end else if (idx >= pool_size || !used_mark[idx] || free_now >= pool_size) begin
            // Out of range, not in use, or nothing left to give back.
            res.status = STATUS_INVALID;
        end else begin
            next_link[idx] = list_head;
            list_head      = idx;
            used_mark[idx] = 1'b0;
            free_now       = free_now + 1;
        end
        res.free_count = COUNT_W'(free_now);
        return res;
    endfunction

    // Follows configuration writes, queues the outcome of each request and checks responses.
    always @(posedge i_clk) begin
        t_pool_outcome got;
        t_pool_outcome want;
        if (!i_rst_n) begin
            restart_pool(RESET_BLOCK_COUNT);
            outcome_q.delete();
            fail_total = 0;
            seen_total = 0;
        end else begin
            if (i_cfg_we) begin
                restart_pool(i_cfg_wdata);
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                seen_total++;
                got.status        = i_rsp_mon.status;
                got.granted_index = i_rsp_mon.granted_index;
                got.free_count    = i_rsp_mon.free_count;
                if (outcome_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("%0t: unexpected response: status %0d index %0d free %0d",
                                 $time, got.status, got.granted_index, got.free_count);
                    end
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("%0t: mismatch: expected status %0d index %0d free %0d,",
                                     $time, want.status, want.granted_index,
                                     want.free_count);
                            $display("    got status %0d index %0d free %0d",
                                     got.status, got.granted_index, got.free_count);
                        end
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                outcome_q.push_back(apply_request(i_req_mon.kind, i_req_mon.block_index));
            end
        end
        o_fail_count <= fail_total;
        o_rsp_seen   <= seen_total;
    end

endmodule

>>> verif/fixed_block_pool_allocator_tb.sv
// Testbench top of the fixed block pool allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
    import fbpa_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int LONG_HOLD      = 64;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BULK_ITEMS     = 300;
    localparam int PHASE_ITEMS    = 35;
    localparam int SMALL_PHASES   = 9;
    localparam int FINAL_ITEMS    = 40;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    int                 fail_count;
    int                 rsp_seen;
    int                 req_sent;
    bit                 quiet;
    bit                 long_hold_req;

    fbpa_req_if req_ch ();
    fbpa_rsp_if rsp_ch ();

    fixed_block_pool_allocator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    fbpa_pool_checker pool_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_mon    (req_ch),
        .i_rsp_mon    (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_rsp_seen   (rsp_seen)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one request, after a random gap unless the run is in its quiet part.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.block_index <= idx;
        do @(posedge clk); while (!req_ch.ready);
        req_sent++;
    endtask

    // Lets the pool go idle, then writes the block count.
    task automatic write_block_count(input logic [COUNT_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (rsp_seen < req_sent) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One pool setting followed by random requests; frees mostly aim inside the pool.
    task automatic run_phase(input logic [COUNT_W-1:0] value, input int items,
                             input int unsigned alloc_pct, input bit hold);
        int unsigned        span;
        logic [INDEX_W-1:0] idx;
        write_block_count(value);
        long_hold_req = hold;
        span = (value == 0) ? 1 : ((value > 256) ? 256 : value);
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                idx = INDEX_W'($urandom_range(0, 255));
            end else begin
                idx = INDEX_W'($urandom_range(0, span - 1));
            end
            if ($urandom_range(0, 99) < alloc_pct) begin
                send_request(KIND_ALLOC, INDEX_W'($urandom));
            end else begin
                send_request(KIND_FREE, idx);
            end
        end
    endtask

    // Response ready: random stall bursts, one long hold on request, none in the quiet part.
    initial begin
        int unsigned hold_cycles;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        forever begin
            if (long_hold_req && !long_hold_done) begin
                rsp_ch.ready   <= 1'b0;
                hold_cycles    = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                hold_cycles  = $urandom_range(1, 8);
            end else begin
                rsp_ch.ready <= 1'b1;
                hold_cycles  = $urandom_range(1, 16);
            end
            repeat (hold_cycles) @(posedge clk);
        end
    end

    // Watchdog: ends the run when nothing has been accepted for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        logic [COUNT_W-1:0] size_value;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= KIND_ALLOC;
        req_ch.block_index <= '0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        rst_n              <= 1'b0;
        quiet              = 1'b0;
        long_hold_req      = 1'b0;
        req_sent           = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fresh blocks in order, a good free, a double free, a free of an unused block,
        // then returned blocks coming back last-in first-out before fresh ones.
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_FREE, 8'd1);
        send_request(KIND_FREE, 8'd1);
        send_request(KIND_FREE, 8'd255);
        send_request(KIND_FREE, 8'd0);
        send_request(KIND_ALLOC, 8'hFF);
        send_request(KIND_ALLOC, 8'hFF);
        send_request(KIND_ALLOC, 8'hFF);

        // A count of zero acts as one: empty pool, full pool and out-of-range frees.
        write_block_count(9'd0);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_FREE, 8'd0);
        send_request(KIND_FREE, 8'd0);
        send_request(KIND_FREE, 8'd1);
        send_request(KIND_FREE, 8'd255);

        // A count above the maximum saturates.
        write_block_count(9'h1FF);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_FREE, 8'd128);

        // Two blocks: run dry, give both back, take them again.
        write_block_count(9'd2);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_FREE, 8'd1);
        send_request(KIND_FREE, 8'd0);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_ALLOC, 8'd0);

        // Full-size pool drained by mostly allocations, with one long response hold.
        run_phase(9'd256, BULK_ITEMS, 97, 1'b1);

        // Small and random pool sizes with mixed traffic.
        for (int p = 0; p < SMALL_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0: size_value = COUNT_W'($urandom);
                1: size_value = COUNT_W'($urandom_range(1, 2));
                default: size_value = COUNT_W'($urandom_range(3, 16));
            endcase
            run_phase(size_value, PHASE_ITEMS, $urandom_range(30, 70), 1'b0);
        end

        // Last part runs back to back on both sides.
        quiet = 1'b1;
        run_phase(COUNT_W'($urandom_range(4, 12)), FINAL_ITEMS, 50, 1'b0);

        req_ch.valid <= 1'b0;
        while (rsp_seen < req_sent) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
